[src/qhs_pkg.sv]
// ----------------------------------------------------------------------------
// qhs_pkg
// Shared types and constants of the quintic Hermite spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package qhs_pkg;

   localparam int DATA_W         = 32;
   localparam int CMD_W          = 2;
   localparam int T_PORT_W       = 17;
   localparam int ACC_W          = 64;
   localparam int HALF_W         = ACC_W / 2;
   localparam int HORNER_STEPS   = 5;
   localparam int SUM_W          = 41;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COEF_WIDTH_DEF = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD_X = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_Y = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

   localparam logic [ACC_W:0] ACC_POS_MAX = (ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
   localparam logic [ACC_W:0] ACC_NEG_MAX = (ACC_W+1)'(1) << (ACC_W - 1);

   localparam logic [DATA_W-1:0] OUT_POS_MAG = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] OUT_NEG_MAG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_LOAD_X,
      KIND_LOAD_Y,
      KIND_EVAL
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     ovf;
   } ctl_type;

endpackage

`default_nettype wire

[src/qhs_coef_gen.sv]
// ----------------------------------------------------------------------------
// qhs_coef_gen
// Head of the chain: weights the endpoint data into the six coefficients,
// saturates them, turns them to sign and magnitude, and holds the leading
// coefficient of each axis as the starting accumulator of evaluate items.
// ----------------------------------------------------------------------------
`default_nettype none

module qhs_coef_gen #(
   parameter int FRAC_BITS  = qhs_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = qhs_pkg::COEF_WIDTH_DEF
) (
   input  wire  logic                                     clock,
   input  wire  logic                                     reset,
   input  wire  logic                                     en,
   input  wire  logic                                     accept,
   input  wire  logic [qhs_pkg::CMD_W-1:0]                cmd,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        pos_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        pos_end,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        slope_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        slope_end,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        accel_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]        accel_end,
   input  wire  logic [qhs_pkg::T_PORT_W-1:0]             param_t,
   output qhs_pkg::ctl_type                               dn_ctl,
   output logic [FRAC_BITS:0]                             dn_t,
   output logic                                           dn_x_sign,
   output logic [qhs_pkg::ACC_W-1:0]                      dn_x_mag,
   output logic                                           dn_y_sign,
   output logic [qhs_pkg::ACC_W-1:0]                      dn_y_mag,
   output logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] dn_bus
);

   localparam int TW    = FRAC_BITS + 1;
   localparam int CMPW  = (TW > qhs_pkg::T_PORT_W) ? TW : qhs_pkg::T_PORT_W;
   localparam int XW    = (qhs_pkg::SUM_W > COEF_WIDTH) ? qhs_pkg::SUM_W : COEF_WIDTH;
   localparam int NCOEF = qhs_pkg::HORNER_STEPS + 1;
   localparam int DW    = qhs_pkg::DATA_W + 1;

   localparam logic [CMPW-1:0] T_ONE = CMPW'(1) << FRAC_BITS;
   localparam logic signed [XW-1:0] C_MAX =
      XW'(signed'({1'b0, {(COEF_WIDTH-1){1'b1}}}));
   localparam logic signed [XW-1:0] C_MIN = ~C_MAX;

   function automatic logic [COEF_WIDTH-1:0] sat_coef(
      input logic signed [qhs_pkg::SUM_W-1:0] v);
      logic signed [XW-1:0] ve;
      ve = XW'(v);
      if (ve > C_MAX) begin
         ve = C_MAX;
      end else if (ve < C_MIN) begin
         ve = C_MIN;
      end
      return ve[COEF_WIDTH-1:0];
   endfunction

   function automatic logic [COEF_WIDTH:0] to_sm(input logic signed [COEF_WIDTH-1:0] v);
      logic [COEF_WIDTH-1:0] m;
      m = v[COEF_WIDTH-1] ? COEF_WIDTH'(-v) : COEF_WIDTH'(v);
      return {v[COEF_WIDTH-1], m};
   endfunction

   // stage 1: pre-sums
   qhs_pkg::ctl_type                   h1_ctl_ff, h1_ctl_in;
   logic [FRAC_BITS:0]                 h1_t_ff, h1_t_in;
   logic [CMPW-1:0]                    t_ext;
   logic signed [DW-1:0]               h1_d_ff, h1_sv_ff, h1_dw_ff;
   logic signed [qhs_pkg::DATA_W-1:0]  h1_p0_ff, h1_v0_ff, h1_v1_ff, h1_w0_ff, h1_w1_ff;

   // stage 2: weighted sums
   qhs_pkg::ctl_type                   h2_ctl_ff;
   logic [FRAC_BITS:0]                 h2_t_ff;
   logic signed [qhs_pkg::SUM_W-1:0]   h2_c_ff [NCOEF];
   logic signed [qhs_pkg::SUM_W-1:0]   h2_c_in [NCOEF];
   logic signed [qhs_pkg::SUM_W-1:0]   dd, ss, ww, v0e, v1e, w0e, w1e, p0e;

   // stage 3: saturated
   qhs_pkg::ctl_type                   h3_ctl_ff;
   logic [FRAC_BITS:0]                 h3_t_ff;
   logic [COEF_WIDTH-1:0]              h3_c_ff [NCOEF];

   // stage 4: sign and magnitude
   qhs_pkg::ctl_type                   h4_ctl_ff;
   logic [FRAC_BITS:0]                 h4_t_ff;
   logic                               h4_x_sign_ff, h4_y_sign_ff;
   logic [qhs_pkg::ACC_W-1:0]          h4_x_mag_ff, h4_y_mag_ff;
   logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] h4_bus_ff;
   logic [COEF_WIDTH:0]                a_x_ff, a_y_ff, a_sm;

   always_comb begin
      h1_ctl_in = '0;
      case (cmd)
         qhs_pkg::CMD_LOAD_X: begin
            h1_ctl_in.valid = accept;
            h1_ctl_in.kind  = qhs_pkg::KIND_LOAD_X;
         end
         qhs_pkg::CMD_LOAD_Y: begin
            h1_ctl_in.valid = accept;
            h1_ctl_in.kind  = qhs_pkg::KIND_LOAD_Y;
         end
         qhs_pkg::CMD_EVAL: begin
            h1_ctl_in.valid = accept;
            h1_ctl_in.kind  = qhs_pkg::KIND_EVAL;
         end
         default: begin
            h1_ctl_in.valid = 1'b0;
            h1_ctl_in.kind  = qhs_pkg::KIND_EVAL;
         end
      endcase
   end

   assign t_ext   = CMPW'(param_t);
   assign h1_t_in = (t_ext > T_ONE) ? TW'(T_ONE) : TW'(t_ext);

   assign dd  = qhs_pkg::SUM_W'(h1_d_ff);
   assign ss  = qhs_pkg::SUM_W'(h1_sv_ff);
   assign ww  = qhs_pkg::SUM_W'(h1_dw_ff);
   assign p0e = qhs_pkg::SUM_W'(h1_p0_ff);
   assign v0e = qhs_pkg::SUM_W'(h1_v0_ff);
   assign v1e = qhs_pkg::SUM_W'(h1_v1_ff);
   assign w0e = qhs_pkg::SUM_W'(h1_w0_ff);
   assign w1e = qhs_pkg::SUM_W'(h1_w1_ff);

   // twice the Hermite weights, d = p1 - p0
   always_comb begin
      h2_c_in[0] = dd * 12 - ss * 6 + ww;
      h2_c_in[1] = v0e * 16 + v1e * 14 + w0e * 3 - w1e * 2 - dd * 30;
      h2_c_in[2] = dd * 20 - v0e * 12 - v1e * 8 - w0e * 3 + w1e;
      h2_c_in[3] = w0e;
      h2_c_in[4] = v0e * 2;
      h2_c_in[5] = p0e * 2;
   end

   assign a_sm = to_sm(h3_c_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_ctl_ff <= '0;
         h2_ctl_ff <= '0;
         h3_ctl_ff <= '0;
         h4_ctl_ff <= '0;
         a_x_ff    <= '0;
         a_y_ff    <= '0;
      end else if (en) begin
         h1_ctl_ff <= h1_ctl_in;
         h2_ctl_ff <= h1_ctl_ff;
         h3_ctl_ff <= h2_ctl_ff;
         h4_ctl_ff <= h3_ctl_ff;
         if (h3_ctl_ff.valid && h3_ctl_ff.kind == qhs_pkg::KIND_LOAD_X) begin
            a_x_ff <= a_sm;
         end
         if (h3_ctl_ff.valid && h3_ctl_ff.kind == qhs_pkg::KIND_LOAD_Y) begin
            a_y_ff <= a_sm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_t_ff  <= h1_t_in;
         h1_d_ff  <= DW'(pos_end) - DW'(pos_start);
         h1_sv_ff <= DW'(slope_start) + DW'(slope_end);
         h1_dw_ff <= DW'(accel_end) - DW'(accel_start);
         h1_p0_ff <= pos_start;
         h1_v0_ff <= slope_start;
         h1_v1_ff <= slope_end;
         h1_w0_ff <= accel_start;
         h1_w1_ff <= accel_end;
         h2_t_ff  <= h1_t_ff;
         h3_t_ff  <= h2_t_ff;
         h4_t_ff  <= h3_t_ff;
         for (int k = 0; k < NCOEF; k++) begin
            h2_c_ff[k] <= h2_c_in[k];
            h3_c_ff[k] <= sat_coef(h2_c_ff[k]);
         end
         for (int k = 0; k < qhs_pkg::HORNER_STEPS; k++) begin
            h4_bus_ff[k] <= to_sm(h3_c_ff[k+1]);
         end
         h4_x_sign_ff <= a_x_ff[COEF_WIDTH];
         h4_x_mag_ff  <= qhs_pkg::ACC_W'(a_x_ff[COEF_WIDTH-1:0]);
         h4_y_sign_ff <= a_y_ff[COEF_WIDTH];
         h4_y_mag_ff  <= qhs_pkg::ACC_W'(a_y_ff[COEF_WIDTH-1:0]);
      end
   end

   assign dn_ctl    = h4_ctl_ff;
   assign dn_t      = h4_t_ff;
   assign dn_x_sign = h4_x_sign_ff;
   assign dn_x_mag  = h4_x_mag_ff;
   assign dn_y_sign = h4_y_sign_ff;
   assign dn_y_mag  = h4_y_mag_ff;
   assign dn_bus    = h4_bus_ff;

endmodule

`default_nettype wire

[src/qhs_horner_cell.sv]
// ----------------------------------------------------------------------------
// qhs_horner_cell
// One Horner step for both axes: acc * t rounded, plus this cell's
// coefficient, saturated. The cell keeps its own coefficient pair and picks
// it off the load bus as a load item passes, so order with evaluates holds.
// ----------------------------------------------------------------------------
`default_nettype none

module qhs_horner_cell #(
   parameter int FRAC_BITS  = qhs_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = qhs_pkg::COEF_WIDTH_DEF
) (
   input  wire  logic                                     clock,
   input  wire  logic                                     reset,
   input  wire  logic                                     en,
   input  wire  qhs_pkg::ctl_type                         up_ctl,
   input  wire  logic [FRAC_BITS:0]                       up_t,
   input  wire  logic                                     up_x_sign,
   input  wire  logic [qhs_pkg::ACC_W-1:0]                up_x_mag,
   input  wire  logic                                     up_y_sign,
   input  wire  logic [qhs_pkg::ACC_W-1:0]                up_y_mag,
   input  wire  logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] up_bus,
   output qhs_pkg::ctl_type                               dn_ctl,
   output logic [FRAC_BITS:0]                             dn_t,
   output logic                                           dn_x_sign,
   output logic [qhs_pkg::ACC_W-1:0]                      dn_x_mag,
   output logic                                           dn_y_sign,
   output logic [qhs_pkg::ACC_W-1:0]                      dn_y_mag,
   output logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] dn_bus
);

   localparam int TW  = FRAC_BITS + 1;
   localparam int PHW = qhs_pkg::HALF_W + TW;
   localparam int PW  = qhs_pkg::ACC_W + TW;
   localparam int AW  = qhs_pkg::ACC_W;

   localparam logic [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

   // returns {saturated, sign, magnitude}
   function automatic logic [AW+1:0] acc_step(
      input logic                  asign,
      input logic [AW-1:0]         r,
      input logic [COEF_WIDTH:0]   c);
      logic [AW:0] ce, re, sum, dpos, dneg;
      logic        csign, osign, sat;
      logic [AW:0] omag;
      csign = c[COEF_WIDTH];
      ce    = (AW+1)'(c[COEF_WIDTH-1:0]);
      re    = {1'b0, r};
      sum   = ce + re;
      dpos  = re - ce;
      dneg  = ce - re;
      sat   = 1'b0;
      if (asign == csign) begin
         osign = csign;
         omag  = sum;
         if (!csign && sum > qhs_pkg::ACC_POS_MAX) begin
            sat  = 1'b1;
            omag = qhs_pkg::ACC_POS_MAX;
         end else if (csign && sum > qhs_pkg::ACC_NEG_MAX) begin
            sat  = 1'b1;
            omag = qhs_pkg::ACC_NEG_MAX;
         end
      end else if (dpos[AW]) begin
         osign = csign;
         omag  = dneg;
      end else begin
         osign = asign;
         omag  = dpos;
      end
      return {sat, osign, omag[AW-1:0]};
   endfunction

   // stage 1: partial products
   qhs_pkg::ctl_type      s1_ctl_ff;
   logic [FRAC_BITS:0]    s1_t_ff;
   logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] s1_bus_ff;
   logic                  s1_x_sign_ff, s1_y_sign_ff;
   logic [PHW-1:0]        s1_xh_ff, s1_xl_ff, s1_yh_ff, s1_yl_ff;
   logic [PHW-1:0]        s1_xh_in, s1_xl_in, s1_yh_in, s1_yl_in;

   // stage 2: rounded acc * t
   qhs_pkg::ctl_type      s2_ctl_ff;
   logic [FRAC_BITS:0]    s2_t_ff;
   logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] s2_bus_ff;
   logic                  s2_x_sign_ff, s2_y_sign_ff;
   logic [AW-1:0]         s2_xr_ff, s2_yr_ff;
   logic [PW-1:0]         px_sum, py_sum;

   // stage 3: accumulate
   qhs_pkg::ctl_type      s3_ctl_ff, s3_ctl_in;
   logic [FRAC_BITS:0]    s3_t_ff;
   logic [qhs_pkg::HORNER_STEPS-1:0][COEF_WIDTH:0] s3_bus_ff;
   logic                  s3_x_sign_ff, s3_y_sign_ff;
   logic [AW-1:0]         s3_x_mag_ff, s3_y_mag_ff;
   logic [AW+1:0]         step_x, step_y;

   logic [COEF_WIDTH:0]   coef_x_ff, coef_y_ff;

   assign s1_xh_in = PHW'(up_x_mag[AW-1:qhs_pkg::HALF_W]) * PHW'(up_t);
   assign s1_xl_in = PHW'(up_x_mag[qhs_pkg::HALF_W-1:0]) * PHW'(up_t);
   assign s1_yh_in = PHW'(up_y_mag[AW-1:qhs_pkg::HALF_W]) * PHW'(up_t);
   assign s1_yl_in = PHW'(up_y_mag[qhs_pkg::HALF_W-1:0]) * PHW'(up_t);

   assign px_sum = (PW'(s1_xh_ff) << qhs_pkg::HALF_W) + PW'(s1_xl_ff) + RND_HALF;
   assign py_sum = (PW'(s1_yh_ff) << qhs_pkg::HALF_W) + PW'(s1_yl_ff) + RND_HALF;

   assign step_x = acc_step(s2_x_sign_ff, s2_xr_ff, coef_x_ff);
   assign step_y = acc_step(s2_y_sign_ff, s2_yr_ff, coef_y_ff);

   always_comb begin
      s3_ctl_in     = s2_ctl_ff;
      s3_ctl_in.ovf = s2_ctl_ff.ovf | step_x[AW+1] | step_y[AW+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         coef_x_ff <= '0;
         coef_y_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= up_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
         if (s2_ctl_ff.valid && s2_ctl_ff.kind == qhs_pkg::KIND_LOAD_X) begin
            coef_x_ff <= s2_bus_ff[0];
         end
         if (s2_ctl_ff.valid && s2_ctl_ff.kind == qhs_pkg::KIND_LOAD_Y) begin
            coef_y_ff <= s2_bus_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_t_ff      <= up_t;
         s1_bus_ff    <= up_bus;
         s1_x_sign_ff <= up_x_sign;
         s1_y_sign_ff <= up_y_sign;
         s1_xh_ff     <= s1_xh_in;
         s1_xl_ff     <= s1_xl_in;
         s1_yh_ff     <= s1_yh_in;
         s1_yl_ff     <= s1_yl_in;
         s2_t_ff      <= s1_t_ff;
         s2_bus_ff    <= s1_bus_ff;
         s2_x_sign_ff <= s1_x_sign_ff;
         s2_y_sign_ff <= s1_y_sign_ff;
         s2_xr_ff     <= px_sum[FRAC_BITS +: AW];
         s2_yr_ff     <= py_sum[FRAC_BITS +: AW];
         s3_t_ff      <= s2_t_ff;
         s3_bus_ff    <= {(COEF_WIDTH+1)'(0),
                          s2_bus_ff[qhs_pkg::HORNER_STEPS-1:1]};
         s3_x_sign_ff <= step_x[AW];
         s3_x_mag_ff  <= step_x[AW-1:0];
         s3_y_sign_ff <= step_y[AW];
         s3_y_mag_ff  <= step_y[AW-1:0];
      end
   end

   assign dn_ctl    = s3_ctl_ff;
   assign dn_t      = s3_t_ff;
   assign dn_bus    = s3_bus_ff;
   assign dn_x_sign = s3_x_sign_ff;
   assign dn_x_mag  = s3_x_mag_ff;
   assign dn_y_sign = s3_y_sign_ff;
   assign dn_y_mag  = s3_y_mag_ff;

endmodule

`default_nettype wire

[src/qhs_round_sat.sv]
// ----------------------------------------------------------------------------
// qhs_round_sat
// Drops the extra fraction bit, rounding half away from zero, and
// saturates each coordinate to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qhs_round_sat (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          en,
   input  wire  qhs_pkg::ctl_type              up_ctl,
   input  wire  logic                          up_x_sign,
   input  wire  logic [qhs_pkg::ACC_W-1:0]     up_x_mag,
   input  wire  logic                          up_y_sign,
   input  wire  logic [qhs_pkg::ACC_W-1:0]     up_y_mag,
   output qhs_pkg::ctl_type                    dn_ctl,
   output logic                                dn_x_sign,
   output logic [qhs_pkg::DATA_W-1:0]          dn_x_mag,
   output logic                                dn_y_sign,
   output logic [qhs_pkg::DATA_W-1:0]          dn_y_mag
);

   localparam int AW = qhs_pkg::ACC_W;
   localparam int OW = qhs_pkg::DATA_W;

   // returns {saturated, magnitude}
   function automatic logic [OW:0] round_sat(input logic sign, input logic [AW-1:0] mag);
      logic [AW:0]   sum;
      logic [AW-1:0] r;
      sum = {1'b0, mag} + (AW+1)'(1);
      r   = sum[AW:1];
      if (sign && r > AW'(qhs_pkg::OUT_NEG_MAG)) begin
         return {1'b1, qhs_pkg::OUT_NEG_MAG};
      end
      if (!sign && r > AW'(qhs_pkg::OUT_POS_MAG)) begin
         return {1'b1, qhs_pkg::OUT_POS_MAG};
      end
      return {1'b0, r[OW-1:0]};
   endfunction

   qhs_pkg::ctl_type  r_ctl_ff, r_ctl_in;
   logic              r_x_sign_ff, r_y_sign_ff;
   logic [OW-1:0]     r_x_mag_ff, r_y_mag_ff;
   logic [OW:0]       rx, ry;

   assign rx = round_sat(up_x_sign, up_x_mag);
   assign ry = round_sat(up_y_sign, up_y_mag);

   always_comb begin
      r_ctl_in     = up_ctl;
      r_ctl_in.ovf = up_ctl.ovf | rx[OW] | ry[OW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff <= '0;
      end else if (en) begin
         r_ctl_ff <= r_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_x_sign_ff <= up_x_sign;
         r_x_mag_ff  <= rx[OW-1:0];
         r_y_sign_ff <= up_y_sign;
         r_y_mag_ff  <= ry[OW-1:0];
      end
   end

   assign dn_ctl    = r_ctl_ff;
   assign dn_x_sign = r_x_sign_ff;
   assign dn_x_mag  = r_x_mag_ff;
   assign dn_y_sign = r_y_sign_ff;
   assign dn_y_mag  = r_y_mag_ff;

endmodule

`default_nettype wire

[src/quintic_hermite_spline_eval.sv]
// ----------------------------------------------------------------------------
// quintic_hermite_spline_eval
// Two-axis quintic Hermite segment evaluator in signed fixed point.
//
// req_ channel: cmd 0 or 1 loads the x or y endpoints (position, slope and
// acceleration at both ends) and gives no item back; cmd 2 evaluates at
// req_param_t (unsigned, 1.0 = 2^FRAC_BITS, larger values read as 1.0);
// cmd 3 is accepted and ignored. rsp_ channel carries x(t), y(t), saturated
// to 32 bits, and an overflow flag.
// One item is taken every cycle unless req_stall is raised. An evaluate
// result passes, once its item is accepted, through four head stages forming
// the coefficients, five Horner cells of three stages each (multiply, round,
// accumulate), one rounding stage and the output register. A load is seen by
// every evaluate accepted after it, even one accepted in the next cycle.
// Reset clears all coefficients to zero and empties the pipeline.
// While a result waits under rsp_stall the chain keeps moving as long as
// its last stage holds no result; otherwise req_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_hermite_spline_eval #(
   parameter int FRAC_BITS  = qhs_pkg::FRAC_BITS_DEF,
   parameter int COEF_WIDTH = qhs_pkg::COEF_WIDTH_DEF
) (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   input  wire  logic                               req_valid,
   output logic                                     req_stall,
   input  wire  logic [qhs_pkg::CMD_W-1:0]          req_cmd,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_pos_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_pos_end,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_slope_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_slope_end,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_accel_start,
   input  wire  logic signed [qhs_pkg::DATA_W-1:0]  req_accel_end,
   input  wire  logic [qhs_pkg::T_PORT_W-1:0]       req_param_t,
   output logic                                     rsp_valid,
   input  wire  logic                               rsp_stall,
   output logic signed [qhs_pkg::DATA_W-1:0]        rsp_point_x,
   output logic signed [qhs_pkg::DATA_W-1:0]        rsp_point_y,
   output logic                                     rsp_overflow
);

   localparam int NS = qhs_pkg::HORNER_STEPS;
   localparam int AW = qhs_pkg::ACC_W;
   localparam int OW = qhs_pkg::DATA_W;

   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic en, out_load, tail_eval, accept;

   qhs_pkg::ctl_type               c_ctl  [NS+1];
   logic [FRAC_BITS:0]             c_t    [NS+1];
   logic                           c_sx   [NS+1];
   logic                           c_sy   [NS+1];
   logic [AW-1:0]                  c_mx   [NS+1];
   logic [AW-1:0]                  c_my   [NS+1];
   logic [NS-1:0][COEF_WIDTH:0]    c_bus  [NS+1];

   qhs_pkg::ctl_type  t_ctl;
   logic              t_x_sign, t_y_sign;
   logic [OW-1:0]     t_x_mag, t_y_mag;

   logic              rsp_valid_ff;
   logic [OW-1:0]     rsp_point_x_ff, rsp_point_y_ff;
   logic              rsp_overflow_ff;

   assign tail_eval = t_ctl.valid && t_ctl.kind == qhs_pkg::KIND_EVAL;
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign en        = out_load || !tail_eval;
   assign req_stall = !en;
   assign accept    = req_valid && en;

   qhs_coef_gen #(
      .FRAC_BITS  (FRAC_BITS),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_head (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .accept      (accept),
      .cmd         (req_cmd),
      .pos_start   (req_pos_start),
      .pos_end     (req_pos_end),
      .slope_start (req_slope_start),
      .slope_end   (req_slope_end),
      .accel_start (req_accel_start),
      .accel_end   (req_accel_end),
      .param_t     (req_param_t),
      .dn_ctl      (c_ctl[0]),
      .dn_t        (c_t[0]),
      .dn_x_sign   (c_sx[0]),
      .dn_x_mag    (c_mx[0]),
      .dn_y_sign   (c_sy[0]),
      .dn_y_mag    (c_my[0]),
      .dn_bus      (c_bus[0])
   );

   for (genvar k = 0; k < NS; k++) begin : g_cell
      qhs_horner_cell #(
         .FRAC_BITS  (FRAC_BITS),
         .COEF_WIDTH (COEF_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_ctl    (c_ctl[k]),
         .up_t      (c_t[k]),
         .up_x_sign (c_sx[k]),
         .up_x_mag  (c_mx[k]),
         .up_y_sign (c_sy[k]),
         .up_y_mag  (c_my[k]),
         .up_bus    (c_bus[k]),
         .dn_ctl    (c_ctl[k+1]),
         .dn_t      (c_t[k+1]),
         .dn_x_sign (c_sx[k+1]),
         .dn_x_mag  (c_mx[k+1]),
         .dn_y_sign (c_sy[k+1]),
         .dn_y_mag  (c_my[k+1]),
         .dn_bus    (c_bus[k+1])
      );
   end

   qhs_round_sat u_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .up_ctl    (c_ctl[NS]),
      .up_x_sign (c_sx[NS]),
      .up_x_mag  (c_mx[NS]),
      .up_y_sign (c_sy[NS]),
      .up_y_mag  (c_my[NS]),
      .dn_ctl    (t_ctl),
      .dn_x_sign (t_x_sign),
      .dn_x_mag  (t_x_mag),
      .dn_y_sign (t_y_sign),
      .dn_y_mag  (t_y_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= tail_eval;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && tail_eval) begin
         rsp_point_x_ff  <= t_x_sign ? (~t_x_mag + OW'(1)) : t_x_mag;
         rsp_point_y_ff  <= t_y_sign ? (~t_y_mag + OW'(1)) : t_y_mag;
         rsp_overflow_ff <= t_ctl.ovf;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_point_x  = signed'(rsp_point_x_ff);
   assign rsp_point_y  = signed'(rsp_point_y_ff);
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_result_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(tail_eval))
      else $error("result raised without an evaluate item in the last stage");

   a_eval_delivered: assert property (@(posedge clock) disable iff (reset)
      (tail_eval && !req_stall) |=> rsp_valid)
      else $error("evaluate item left the chain without a result");

   a_bus_drained: assert property (@(posedge clock) disable iff (reset)
      c_ctl[NS].valid |-> (c_bus[NS] == '0))
      else $error("load bus not empty after the last cell");

   a_t_clamped: assert property (@(posedge clock) disable iff (reset)
      c_ctl[NS].valid |-> (c_t[NS] <= T_ONE))
      else $error("curve parameter above one in the chain");
`endif

endmodule

`default_nettype wire

[sim/qhs_point_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qhs_point_checker
// Watches the req_ and rsp_ channels of the quintic Hermite spline evaluator.
// It keeps its own x and y coefficient sets, forms them on every accepted
// load, works out x(t), y(t) and the overflow flag on every accepted
// evaluate, and compares each accepted result with the oldest expected point.
// ----------------------------------------------------------------------------
module qhs_point_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic [qhs_pkg::CMD_W-1:0]               req_cmd,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_pos_start,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_pos_end,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_slope_start,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_slope_end,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_accel_start,
   input  logic signed [qhs_pkg::DATA_W-1:0]       req_accel_end,
   input  logic [qhs_pkg::T_PORT_W-1:0]            req_param_t,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [qhs_pkg::DATA_W-1:0]       rsp_point_x,
   input  logic signed [qhs_pkg::DATA_W-1:0]       rsp_point_y,
   input  logic                                    rsp_overflow,
   output int                                      outstanding,
   output int                                      failures
);

   localparam int          FRAC      = qhs_pkg::FRAC_BITS_DEF;
   localparam int          COEF_W    = qhs_pkg::COEF_WIDTH_DEF;
   localparam logic [63:0] T_ONE     = 64'd1 << FRAC;
   localparam logic [63:0] FRAC_MASK = T_ONE - 64'd1;
   localparam logic [63:0] HALF_LSB  = T_ONE >> 1;
   localparam longint      TERM_MAX  = (longint'(1) <<< (COEF_W - 1)) - 1;
   localparam longint      TERM_MIN  = -TERM_MAX - 1;
   localparam longint      ACC_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint      ACC_MIN   = 64'sh8000_0000_0000_0000;

   // index 0 holds the t^5 term, index 5 the constant; all hold twice the value
   typedef logic [5:0][63:0] term_set_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic        ovf;
   } point_type;

   term_set_type x_terms;
   term_set_type y_terms;
   point_type    expected_points[$];

   function automatic logic [63:0] clamp_term(input longint v);
      if (v > TERM_MAX) return TERM_MAX;
      if (v < TERM_MIN) return TERM_MIN;
      return v;
   endfunction

   function automatic term_set_type form_terms(input longint p0, p1, v0, v1, w0, w1);
      term_set_type c;
      c[0] = clamp_term(-12 * p0 - 6 * v0 - w0 + w1 - 6 * v1 + 12 * p1);
      c[1] = clamp_term(30 * p0 + 16 * v0 + 3 * w0 - 2 * w1 + 14 * v1 - 30 * p1);
      c[2] = clamp_term(-20 * p0 - 12 * v0 - 3 * w0 + w1 - 8 * v1 + 20 * p1);
      c[3] = clamp_term(w0);
      c[4] = clamp_term(2 * v0);
      c[5] = clamp_term(2 * p0);
      return c;
   endfunction

   // bit 32 is the saturation flag, bits 31:0 the coordinate
   function automatic logic [32:0] axis_value(input term_set_type c, input logic [63:0] t);
      longint             acc;
      logic [63:0]        mag;
      logic [63:0]        r;
      logic signed [64:0] s;
      logic               ovf;
      int                 k;
      ovf = 1'b0;
      acc = $signed(c[0]);
      for (k = 1; k < 6; k++) begin
         mag = acc[63] ? 64'd0 - acc : acc;
         r = (mag >> FRAC) * t + (((mag & FRAC_MASK) * t + HALF_LSB) >> FRAC);
         if (r > mag) r = mag;
         acc = acc[63] ? 64'd0 - r : r;
         s = acc + $signed(c[k]);
         if (s[64] != s[63]) begin
            ovf = 1'b1;
            acc = s[64] ? ACC_MIN : ACC_MAX;
         end else begin
            acc = s[63:0];
         end
      end
      mag = acc[63] ? 64'd0 - acc : acc;
      r = (mag + 64'd1) >> 1;
      if (acc[63]) begin
         if (r > 64'h8000_0000) begin
            ovf = 1'b1;
            r = 64'h8000_0000;
         end
         r = 64'd0 - r;
      end else if (r > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         r = 64'h7FFF_FFFF;
      end
      return {ovf, r[31:0]};
   endfunction

   always @(posedge clock) begin : watch
      point_type   want;
      point_type   point;
      logic [63:0] t;
      logic [32:0] xv;
      logic [32:0] yv;
      if (reset) begin
         x_terms = '0;
         y_terms = '0;
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("result with no evaluate outstanding: x %0d y %0d",
                      rsp_point_x, rsp_point_y);
               failures = failures + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.x) begin
                  $error("point_x: expected %0d, got %0d", $signed(want.x), rsp_point_x);
                  failures = failures + 1;
               end
               if (rsp_point_y !== want.y) begin
                  $error("point_y: expected %0d, got %0d", $signed(want.y), rsp_point_y);
                  failures = failures + 1;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_overflow);
                  failures = failures + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               qhs_pkg::CMD_LOAD_X: begin
                  x_terms = form_terms(req_pos_start, req_pos_end, req_slope_start,
                                       req_slope_end, req_accel_start, req_accel_end);
               end
               qhs_pkg::CMD_LOAD_Y: begin
                  y_terms = form_terms(req_pos_start, req_pos_end, req_slope_start,
                                       req_slope_end, req_accel_start, req_accel_end);
               end
               qhs_pkg::CMD_EVAL: begin
                  t = (req_param_t > T_ONE) ? T_ONE : 64'(req_param_t);
                  xv = axis_value(x_terms, t);
                  yv = axis_value(y_terms, t);
                  point.x = xv[31:0];
                  point.y = yv[31:0];
                  point.ovf = xv[32] | yv[32];
                  expected_points.push_back(point);
               end
               default: ;
            endcase
         end
      end
      outstanding <= expected_points.size();
   end

endmodule

[sim/quintic_hermite_spline_eval_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quintic_hermite_spline_eval_tb
// Drives the spline evaluator with a directed set of loads and evaluates
// (field extremes, t at and beyond one, the unused command, a load followed
// at once by an evaluate) and then random load and evaluate traffic with
// random idle cycles on both channels. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module quintic_hermite_spline_eval_tb;

   localparam logic [qhs_pkg::CMD_W-1:0] CMD_IGNORED = 2'd3;
   localparam int                 ITEM_COUNT   = 1550;
   localparam int                 PAUSE_AT     = 400;
   localparam int                 STEADY_FIRST = 700;
   localparam int                 STEADY_LAST  = 1000;
   localparam logic [16:0]        T_ONE        = 17'd1 << qhs_pkg::FRAC_BITS_DEF;
   localparam logic [31:0]        D_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0]        D_MIN        = 32'h8000_0000;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic [qhs_pkg::CMD_W-1:0]     req_cmd         = '0;
   logic signed [31:0]            req_pos_start   = '0;
   logic signed [31:0]            req_pos_end     = '0;
   logic signed [31:0]            req_slope_start = '0;
   logic signed [31:0]            req_slope_end   = '0;
   logic signed [31:0]            req_accel_start = '0;
   logic signed [31:0]            req_accel_end   = '0;
   logic [16:0]                   req_param_t     = '0;
   logic                          rsp_stall       = 1'b0;
   logic                          steady          = 1'b1;
   logic                          req_stall;
   logic                          rsp_valid;
   logic signed [31:0]            rsp_point_x;
   logic signed [31:0]            rsp_point_y;
   logic                          rsp_overflow;
   int                            outstanding;
   int                            failures;

   quintic_hermite_spline_eval u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_start   (req_pos_start),
      .req_pos_end     (req_pos_end),
      .req_slope_start (req_slope_start),
      .req_slope_end   (req_slope_end),
      .req_accel_start (req_accel_start),
      .req_accel_end   (req_accel_end),
      .req_param_t     (req_param_t),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_overflow    (rsp_overflow)
   );

   qhs_point_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_pos_start   (req_pos_start),
      .req_pos_end     (req_pos_end),
      .req_slope_start (req_slope_start),
      .req_slope_end   (req_slope_end),
      .req_accel_start (req_accel_start),
      .req_accel_end   (req_accel_end),
      .req_param_t     (req_param_t),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_overflow    (rsp_overflow),
      .outstanding     (outstanding),
      .failures        (failures)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 21);
   end

   task automatic send_item(input logic [1:0] cmd, input logic [31:0] p0, p1, v0, v1,
                            w0, w1, input logic [16:0] t);
      if (!steady) begin
         while ($urandom_range(99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pos_start   <= p0;
      req_pos_end     <= p1;
      req_slope_start <= v0;
      req_slope_end   <= v1;
      req_accel_start <= w0;
      req_accel_end   <= w1;
      req_param_t     <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every evaluate has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] draw_coord();
      case ($urandom_range(9))
         0, 1, 2, 3: return 32'($urandom_range(32'h1F_FFFF)) - 32'h10_0000;
         4, 5, 6:    return 32'($urandom_range(32'hFFF_FFFF)) - 32'h800_0000;
         7, 8:       return $urandom();
         default: begin
            case ($urandom_range(3))
               0:       return D_MAX;
               1:       return D_MIN;
               2:       return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [16:0] draw_t();
      case ($urandom_range(19))
         0, 1:    return 17'd0;
         2, 3:    return T_ONE;
         4:       return 17'($urandom_range(17'h1FFFF, T_ONE + 1));
         default: return 17'($urandom_range(T_ONE - 1));
      endcase
   endfunction

   task automatic send_load(input logic [1:0] cmd);
      send_item(cmd, draw_coord(), draw_coord(), draw_coord(), draw_coord(),
                draw_coord(), draw_coord(), 17'($urandom_range(17'h1FFFF)));
   endtask

   initial begin
      int sent;
      int pick;
      int burst;
      bit paused;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // coefficients still at reset
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd32768);
      send_item(qhs_pkg::CMD_LOAD_X, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, 17'd0);
      send_item(qhs_pkg::CMD_LOAD_Y, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, 17'h1FFFF);
      send_item(qhs_pkg::CMD_EVAL, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd32768);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, T_ONE);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'h1FFFF);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, T_ONE + 17'd1);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd1);
      send_item(CMD_IGNORED, '1, '1, '1, '1, '1, '1, '1);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd16384);
      // a gentle segment, evaluated straight after each load
      send_item(qhs_pkg::CMD_LOAD_X, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
                32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd21845);
      send_item(qhs_pkg::CMD_LOAD_Y, 32'hFFFD_0000, 32'h0002_8000, 32'h0,
                32'h0004_0000, 32'hFFFE_C000, 32'h0003_0000, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd65535);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, T_ONE);
      // steep slopes at both ends, evaluated at the middle of the curve
      send_item(qhs_pkg::CMD_LOAD_X, 0, 0, D_MAX, D_MAX, 0, 0, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd32768);
      send_item(qhs_pkg::CMD_LOAD_X, 0, 0, 0, 0, 0, 0, 17'd0);
      send_item(qhs_pkg::CMD_LOAD_Y, 0, 0, 0, 0, 0, 0, 17'd0);
      send_item(qhs_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 0, 17'd40000);
      settle();

      sent = 0;
      paused = 1'b0;
      while (sent < ITEM_COUNT) begin
         steady <= (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
         if (!paused && sent >= PAUSE_AT) begin
            settle();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_load(qhs_pkg::CMD_LOAD_X);
            sent++;
         end else if (pick < 24) begin
            send_load(qhs_pkg::CMD_LOAD_Y);
            sent++;
         end else if (pick < 28) begin
            send_load(CMD_IGNORED);
         end else begin
            burst = $urandom_range(6, 1);
            repeat (burst) begin
               send_item(qhs_pkg::CMD_EVAL, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), draw_t());
               sent++;
            end
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
src/qhs_pkg.sv
src/qhs_coef_gen.sv
src/qhs_horner_cell.sv
src/qhs_round_sat.sv
src/quintic_hermite_spline_eval.sv
sim/qhs_point_checker.sv
sim/quintic_hermite_spline_eval_tb.sv
